FILE: src/fdlr_pkg.sv
// Package for the flank density log ratio block: widths, register indexes,
// reset values and fixed-point constants. No dependencies.
`timescale 1ns / 1ps
package fdlr_pkg;
   localparam int COORD_BITS_DEF = 32;
   localparam int SUM_BITS_DEF   = 48;
   localparam int CHROM_W        = 8;
   localparam int DIST_W         = 28;
   localparam int VALUE_W        = 32;
   localparam int RATIO_W        = 24;
   localparam int STATUS_W       = 2;
   localparam int LOG_FRAC       = 28;
   localparam int IDX_W          = 3;
   localparam logic [DIST_W-1:0] MIN_DIST_RESET = 28'd3000;
   localparam logic [DIST_W-1:0] MAX_DIST_RESET = 28'd500000;
   localparam logic [31:0] LN2_Q28 = 32'd186065280;

   localparam logic [IDX_W-1:0] REG_TARGET_CHROM = 3'd0;
   localparam logic [IDX_W-1:0] REG_TARGET_START = 3'd1;
   localparam logic [IDX_W-1:0] REG_TARGET_END   = 3'd2;
   localparam logic [IDX_W-1:0] REG_MIN_DIST     = 3'd3;
   localparam logic [IDX_W-1:0] REG_MAX_DIST     = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accumulate;   // test and add the captured record
      logic fin_start;    // latch spans and status for the final pass
      logic log_load;     // load the log unit with operand selected by log_sel
      logic [1:0] log_sel;// 0 up_sum, 1 up_span, 2 down_sum, 3 down_span
      logic log_step;     // one squaring step of the log unit
      logic log_take;     // fold the finished log into the difference
      logic mul_step;     // one partial product of the ln2 scaling
      logic finish;       // form the result and clear the accumulators
   } cmd_type;

   // Status back to the controller.
   typedef struct packed {
      logic flagged;      // a window is empty or zero
   } stat_type;
endpackage

FILE: src/fdlr_ctrl.sv
// Controller for the flank density log ratio block: sequences the record
// accumulate and the final log pass. Uses fdlr_pkg.
`timescale 1ns / 1ps
module fdlr_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic in_last,
   output logic in_ready,
   output logic out_valid,
   input  logic out_ready,
   input  fdlr_pkg::stat_type stat,
   output fdlr_pkg::cmd_type cmd
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_FIN, ST_LOAD, ST_LOG, ST_TAKE, ST_MUL, ST_DONE, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] sel_ff, sel_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       acc_fire;

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_OUT);
   assign acc_fire  = in_valid && in_ready;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.log_sel = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc_fire) begin
               cmd.accumulate = 1'b1;
               if (in_last) state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.fin_start = 1'b1;
            sel_in = 2'd0;
            state_in = stat.flagged ? ST_DONE : ST_LOAD;
         end
         ST_LOAD: begin
            cmd.log_load = 1'b1;
            cnt_in = 5'd0;
            state_in = ST_LOG;
         end
         ST_LOG: begin
            cmd.log_step = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(fdlr_pkg::LOG_FRAC - 1)) state_in = ST_TAKE;
         end
         ST_TAKE: begin
            cmd.log_take = 1'b1;
            sel_in = sel_ff + 2'd1;
            cnt_in = 5'd0;
            state_in = (sel_ff == 2'd3) ? ST_MUL : ST_LOAD;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd1) state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= 2'd0;
         cnt_ff   <= 5'd0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         cnt_ff   <= cnt_in;
      end
   end

   // The log pass never runs for a flagged result.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && stat.flagged) |=> state_ff == ST_DONE)
      else $error("flagged result entered log pass");
   // A result is offered only after finish.
   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid) |-> $past(cmd.finish))
      else $error("result without finish");
   // No record is taken while a result waits.
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> !in_ready)
      else $error("input open during output");
endmodule

FILE: src/fdlr_datapath.sv
// Datapath for the flank density log ratio block: window tests, saturating
// sums, extents, an iterative log2 unit and the ln2 scaling. Uses fdlr_pkg.
`timescale 1ns / 1ps
module fdlr_datapath #(
   parameter int COORD_BITS = fdlr_pkg::COORD_BITS_DEF,
   parameter int SUM_BITS   = fdlr_pkg::SUM_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  fdlr_pkg::cmd_type cmd,
   output fdlr_pkg::stat_type stat,
   input  logic [fdlr_pkg::CHROM_W-1:0] target_chrom,
   input  logic [COORD_BITS-1:0] target_start,
   input  logic [COORD_BITS-1:0] target_end,
   input  logic [fdlr_pkg::DIST_W-1:0] min_distance,
   input  logic [fdlr_pkg::DIST_W-1:0] max_distance,
   input  logic [fdlr_pkg::CHROM_W-1:0] chrom_id,
   input  logic [COORD_BITS-1:0] rec_start,
   input  logic [COORD_BITS-1:0] rec_end,
   input  logic [fdlr_pkg::VALUE_W-1:0] pile_value,
   output logic signed [fdlr_pkg::RATIO_W-1:0] direction_ratio,
   output logic [fdlr_pkg::STATUS_W-1:0] status
);
   localparam int DW  = COORD_BITS + 3;            // signed doubled distance
   localparam int OPW = (SUM_BITS > COORD_BITS) ? SUM_BITS : COORD_BITS;
   localparam int KW  = $clog2(OPW);
   localparam int FR  = fdlr_pkg::LOG_FRAC;
   localparam int LW  = KW + FR + 2;               // signed log difference
   localparam int MAGW = LW - 1;
   localparam logic [COORD_BITS-1:0] CMAX = '1;
   localparam logic [SUM_BITS-1:0]   SMAX = '1;

   logic [SUM_BITS-1:0]   up_sum_ff, down_sum_ff;
   logic [COORD_BITS-1:0] up_low_ff, up_high_ff, down_low_ff, down_high_ff;
   logic                  up_seen_ff, down_seen_ff;
   logic [COORD_BITS-1:0] up_span_ff, down_span_ff;
   logic [1:0]            flag_ff;
   logic [30:0]           mant_ff;                // Q1.30, below 2^31
   logic [KW-1:0]         exp_ff;
   logic [FR-1:0]         frac_ff;
   logic signed [LW-1:0]  diff_ff;
   logic [MAGW+31:0]      prod_ff;
   logic signed [fdlr_pkg::RATIO_W-1:0] ratio_ff;
   logic [1:0]            status_ff;

   // Window tests at doubled scale.
   logic signed [DW-1:0] mid2, de, ds, mn2, mx2;
   logic on_chrom, in_down, in_up;
   assign mid2 = DW'(target_start) + DW'(target_end);
   assign de   = (DW'(rec_end) <<< 1) - mid2;
   assign ds   = (DW'(rec_start) <<< 1) - mid2;
   assign mn2  = DW'({min_distance, 1'b0});
   assign mx2  = DW'({max_distance, 1'b0});
   assign on_chrom = (chrom_id == target_chrom);
   assign in_down  = on_chrom && (de > mn2) && (ds < mx2);
   assign in_up    = on_chrom && (de > -mx2) && (ds < -mn2);

   // Saturating adds.
   logic [SUM_BITS:0] up_add, down_add;
   assign up_add   = {1'b0, up_sum_ff} + (SUM_BITS+1)'(pile_value);
   assign down_add = {1'b0, down_sum_ff} + (SUM_BITS+1)'(pile_value);

   // Spans.
   logic [COORD_BITS-1:0] up_span, down_span;
   assign up_span   = (up_high_ff > up_low_ff) ? up_high_ff - up_low_ff : '0;
   assign down_span = (down_high_ff > down_low_ff) ? down_high_ff - down_low_ff : '0;
   logic [1:0] flag_now;
   assign flag_now[0] = !up_seen_ff || (up_span == '0) || (up_sum_ff == '0);
   assign flag_now[1] = !down_seen_ff || (down_span == '0) || (down_sum_ff == '0);
   assign stat.flagged = |flag_now;

   // Log operand select and normalization (priority encoder).
   logic [OPW-1:0] op;
   logic [KW-1:0]  top;
   logic [OPW-1:0] norm;
   always_comb begin
      case (cmd.log_sel)
         2'd0:    op = OPW'(up_sum_ff);
         2'd1:    op = OPW'(up_span_ff);
         2'd2:    op = OPW'(down_sum_ff);
         default: op = OPW'(down_span_ff);
      endcase
      top = '0;
      for (int i = 0; i < OPW; i++) begin
         if (op[i]) top = KW'(i);
      end
      norm = op << (KW'(OPW - 1) - top);
   end
   logic [30:0] mant_init;
   assign mant_init = (OPW >= 31) ? 31'(norm >> (OPW - 31)) : 31'(norm) << (31 - OPW);
   // Note: the top bit of mant_init is the leading one (value in [2^30, 2^31)).

   // One squaring step.
   logic [61:0] sq;
   logic [31:0] sq_sh;
   assign sq    = 62'(mant_ff) * 62'(mant_ff);
   assign sq_sh = sq[61:30];

   logic signed [LW-1:0] lg;
   assign lg = LW'({exp_ff, frac_ff});

   // ln2 scaling on |diff| in two halves.
   logic neg;
   logic [MAGW-1:0] mag;
   localparam int HW = (MAGW + 1) / 2;
   assign neg = diff_ff[LW-1];
   assign mag = neg ? MAGW'(-diff_ff) : MAGW'(diff_ff);
   logic [HW-1:0] half;
   assign half = prod_ff[MAGW+31] ? HW'(mag >> HW) : HW'(mag);
   logic [MAGW+31:0] pp;
   assign pp = (MAGW+32)'(half) * (MAGW+32)'(fdlr_pkg::LN2_Q28);

   logic [MAGW+31:0] rnd;
   logic [MAGW-9:0]  q;
   assign rnd = {1'b0, prod_ff[MAGW+30:0]} + ((MAGW+32)'(1) << 39);
   assign q   = rnd[MAGW+31:40];
   logic signed [fdlr_pkg::RATIO_W-1:0] sat;
   always_comb begin
      if (q >= (MAGW-8)'(23'h7FFFFF)) sat = neg ? -24'sd8388607 - 24'sd1 : 24'sd8388607;
      else sat = neg ? -$signed(24'(q)) : $signed(24'(q));
      if (q == (MAGW-8)'(23'h7FFFFF)) sat = neg ? -24'sd8388607 : 24'sd8388607;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_sum_ff <= '0; down_sum_ff <= '0;
         up_low_ff <= CMAX; down_low_ff <= CMAX;
         up_high_ff <= '0; down_high_ff <= '0;
         up_seen_ff <= 1'b0; down_seen_ff <= 1'b0;
         status_ff <= '0; ratio_ff <= '0;
      end else begin
         if (cmd.accumulate) begin
            if (in_down) begin
               down_sum_ff <= down_add[SUM_BITS] ? SMAX : down_add[SUM_BITS-1:0];
               if (rec_start < down_low_ff) down_low_ff <= rec_start;
               if (rec_end > down_high_ff) down_high_ff <= rec_end;
               down_seen_ff <= 1'b1;
            end
            if (in_up) begin
               up_sum_ff <= up_add[SUM_BITS] ? SMAX : up_add[SUM_BITS-1:0];
               if (rec_start < up_low_ff) up_low_ff <= rec_start;
               if (rec_end > up_high_ff) up_high_ff <= rec_end;
               up_seen_ff <= 1'b1;
            end
         end
         if (cmd.finish) begin
            status_ff <= flag_ff;
            ratio_ff  <= (flag_ff != 2'b00) ? '0 : sat;
            up_sum_ff <= '0; down_sum_ff <= '0;
            up_low_ff <= CMAX; down_low_ff <= CMAX;
            up_high_ff <= '0; down_high_ff <= '0;
            up_seen_ff <= 1'b0; down_seen_ff <= 1'b0;
         end
      end
   end

   // Final pass registers (payload, no reset).
   always_ff @(posedge clock) begin
      if (cmd.fin_start) begin
         up_span_ff   <= up_span;
         down_span_ff <= down_span;
         flag_ff      <= flag_now;
         diff_ff      <= '0;
         prod_ff      <= '0;
      end
      if (cmd.log_load) begin
         mant_ff <= mant_init;
         exp_ff  <= top;
         frac_ff <= '0;
      end
      if (cmd.log_step) begin
         if (sq_sh[31]) begin
            mant_ff <= sq_sh[31:1];
            frac_ff <= {frac_ff[FR-2:0], 1'b1};
         end else begin
            mant_ff <= sq_sh[30:0];
            frac_ff <= {frac_ff[FR-2:0], 1'b0};
         end
      end
      if (cmd.log_take) begin
         if (cmd.log_sel == 2'd0 || cmd.log_sel == 2'd3) diff_ff <= diff_ff + lg;
         else diff_ff <= diff_ff - lg;
      end
      // Low half first (marker in the top bit), then high half shifted up.
      if (cmd.mul_step) begin
         if (!prod_ff[MAGW+31]) prod_ff <= {1'b1, pp[MAGW+30:0]};
         else prod_ff <= {1'b0, prod_ff[MAGW+30:0] + (pp[MAGW+30:0] << HW)};
      end
   end

   assign direction_ratio = ratio_ff;
   assign status          = status_ff;

   // A zero upstream status bit implies the upstream window was seen.
   assert property (@(posedge clock) disable iff (reset)
      cmd.fin_start && !flag_now[0] |-> up_seen_ff)
      else $error("upstream passed without records");
   // Accumulators are clear after finish.
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (up_sum_ff == '0) && !down_seen_ff)
      else $error("accumulators not cleared");
   // Flagged results carry a zero ratio.
   assert property (@(posedge clock) disable iff (reset)
      $past(cmd.finish) && status_ff != 2'b00 |-> ratio_ff == '0)
      else $error("flagged nonzero ratio");
endmodule

FILE: src/flank_density_log_ratio.sv
// Top level of the flank density log ratio block: register file, controller
// and datapath. Uses fdlr_pkg, fdlr_ctrl and fdlr_datapath.
`timescale 1ns / 1ps
// Usage:
// Pile-up records enter on the req_ stream; req_tlast marks the final record
// of a data set. Records that are not last are taken back to back, one per
// cycle: each is tested and accumulated in the cycle it is accepted, and the
// controller stays idle. After the last record the block computes four
// fixed-point logs, each a load, 28 squaring steps of one shared multiplier
// and a fold, then two partial products for the ln2 scaling and a final
// step to form the result, which then raises rsp_tvalid. When a window is
// empty or zero the logs and the scaling are skipped and the ratio is zero.
// The result waits on rsp_ until taken; while it waits no record is taken, and
// records are taken again from the cycle after the result is taken. Registers
// are written on the csr_ channel, always ready; the user must write them only
// while idle, the block itself does not enforce it. Reset clears the registers
// to defaults, empties both windows; the accumulators clear after every result.
module flank_density_log_ratio #(
   parameter int COORD_BITS = fdlr_pkg::COORD_BITS_DEF,
   parameter int SUM_BITS   = fdlr_pkg::SUM_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // chrom_id[7:0], rec_start[39:8], rec_end[71:40], pile_value[103:72]
   input  logic [103:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // direction_ratio[23:0], status[25:24], zero fill to 32 bits
   output logic [31:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [fdlr_pkg::IDX_W-1:0] csr_index,
   input  logic [31:0]  csr_data
);
   logic [fdlr_pkg::CHROM_W-1:0] chrom_ff;
   logic [COORD_BITS-1:0] tstart_ff, tend_ff;
   logic [fdlr_pkg::DIST_W-1:0] mind_ff, maxd_ff;
   fdlr_pkg::cmd_type  cmd;
   fdlr_pkg::stat_type stat;
   logic signed [fdlr_pkg::RATIO_W-1:0] ratio;
   logic [fdlr_pkg::STATUS_W-1:0] status;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         chrom_ff  <= '0;
         tstart_ff <= '0;
         tend_ff   <= '0;
         mind_ff   <= fdlr_pkg::MIN_DIST_RESET;
         maxd_ff   <= fdlr_pkg::MAX_DIST_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            fdlr_pkg::REG_TARGET_CHROM: chrom_ff  <= csr_data[7:0];
            fdlr_pkg::REG_TARGET_START: tstart_ff <= COORD_BITS'(csr_data);
            fdlr_pkg::REG_TARGET_END:   tend_ff   <= COORD_BITS'(csr_data);
            fdlr_pkg::REG_MIN_DIST:     mind_ff   <= csr_data[27:0];
            fdlr_pkg::REG_MAX_DIST:     maxd_ff   <= csr_data[27:0];
            default: ;
         endcase
      end
   end

   fdlr_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_last(req_tlast), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .stat(stat), .cmd(cmd)
   );

   fdlr_datapath #(.COORD_BITS(COORD_BITS), .SUM_BITS(SUM_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .target_chrom(chrom_ff), .target_start(tstart_ff), .target_end(tend_ff),
      .min_distance(mind_ff), .max_distance(maxd_ff),
      .chrom_id(req_tdata[7:0]),
      .rec_start(COORD_BITS'(req_tdata[39:8])),
      .rec_end(COORD_BITS'(req_tdata[71:40])),
      .pile_value(req_tdata[103:72]),
      .direction_ratio(ratio), .status(status)
   );

   assign rsp_tdata = {6'd0, status, ratio};
endmodule
